@@ hw/rtl/was_pkg.sv @@
// Shared constants, codes and types of the weekly alarm scheduler.
package was_pkg;

  localparam int SLOTS_PER_DAY = 16;
  localparam int DAYS          = 7;
  localparam int DAY_W         = 3;
  localparam int MIN_W         = 11;
  localparam int TAG_W         = 8;
  localparam int FILL_W        = $clog2(SLOTS_PER_DAY + 1);
  localparam int DIFF_W        = 14;
  localparam int WAIT_W        = 20;
  localparam int LIM_W         = 17;

  localparam int MAX_HOUR      = 23;
  localparam int MAX_MINUTE    = 59;
  localparam int MIN_PER_HOUR  = 60;
  localparam int SEC_PER_MIN   = 60;
  localparam int MIN_PER_DAY   = 1440;

  localparam logic [15:0] RELAY_INTERVAL_RST = 16'(60 * 60);
  localparam logic [15:0] RELAY_OFFSET_RST   = 16'(5 * 60);

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  localparam logic CFG_INTERVAL = 1'b0;
  localparam logic CFG_OFFSET   = 1'b1;

  typedef logic [DAYS-1:0][MIN_W-1:0] min_row_t;
  typedef logic [DAYS-1:0][TAG_W-1:0] tag_row_t;

  typedef struct packed {
    logic [DAYS-1:0]  wr_mask;
    logic [MIN_W-1:0] wr_minute;
    logic [TAG_W-1:0] wr_tag;
    logic [DAY_W-1:0] q_day;
    logic [MIN_W-1:0] q_now;
  } cell_ctl_t;

  typedef struct packed {
    logic             found;
    logic [MIN_W-1:0] minute;
    logic [TAG_W-1:0] tag;
  } chain_t;

endpackage

@@ hw/rtl/weekly_alarm_scheduler_top.sv @@
// Weekly alarm scheduler: top level with controller, slot chain and output register.
//
// Each weekday keeps a sorted list of up to SLOTS_PER_DAY alarms held in a row of
// slot cells. Clear and append go from the execute state straight to the done state.
// A query runs the search chain of the cells for the current weekday in the scan
// state, then looks at the head of one later weekday per cycle, up to seven, and
// does the wait arithmetic in the calc and compare states. One transaction is in
// work at a time; input stalls until its result has moved into the output register.
module weekly_alarm_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [4:0]  hour_value,
  input  logic [5:0]  minute_value,
  input  logic [6:0]  day_mask,
  input  logic [7:0]  alarm_tag,
  input  logic [2:0]  now_weekday,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        op_ok,
  output logic [19:0] wait_sec,
  output logic        is_relay,
  output logic [7:0]  next_tag,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import was_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_NEXT, S_CALC, S_CMP, S_DONE
  } state_t;

  state_t state;

  logic [1:0]       func_r;
  logic [4:0]       hour_r;
  logic [5:0]       minute_r;
  logic [DAYS-1:0]  mask_r;
  logic [TAG_W-1:0] tag_r;
  logic [DAY_W-1:0] wday_r;
  logic [DAY_W-1:0] day_r;
  logic [DAY_W-1:0] k_r;
  logic [FILL_W-1:0] cnt_r;
  logic [DIFF_W-1:0] diff_r;
  logic [WAIT_W-1:0] wait_r;
  logic [LIM_W-1:0]  lim_r;
  logic [15:0]       interval;
  logic [15:0]       offset;
  logic [DAYS-1:0][FILL_W-1:0] fill;

  logic              res_ok;
  logic [WAIT_W-1:0] res_wait;
  logic              res_relay;
  logic [TAG_W-1:0]  res_tag;

  logic [4:0]       hour_c;
  logic [5:0]       minute_c;
  logic [MIN_W-1:0] now_c;
  logic [DAY_W-1:0] day_next;
  logic             append_ok;
  logic [DAYS-1:0]  full;
  cell_ctl_t        ctl;

  logic [DAYS-1:0] valid_v [SLOTS_PER_DAY];
  logic [DAYS-1:0] gt_v    [SLOTS_PER_DAY + 1];
  min_row_t        min_v   [SLOTS_PER_DAY + 1];
  tag_row_t        tag_v   [SLOTS_PER_DAY + 1];
  chain_t          chain_v [SLOTS_PER_DAY + 1];

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign hour_c   = (hour_r > 5'(MAX_HOUR)) ? 5'(MAX_HOUR) : hour_r;
  assign minute_c = (minute_r > 6'(MAX_MINUTE)) ? 6'(MAX_MINUTE) : minute_r;
  assign now_c    = MIN_W'(hour_c) * MIN_W'(MIN_PER_HOUR) + MIN_W'(minute_c);
  assign day_next = (day_r == DAY_W'(DAYS - 1)) ? '0 : day_r + 1'b1;

  always_comb begin
    for (int d = 0; d < DAYS; d++) begin
      full[d] = (fill[d] == FILL_W'(SLOTS_PER_DAY));
    end
  end

  assign append_ok = (hour_r <= 5'(MAX_HOUR)) && (minute_r <= 6'(MAX_MINUTE)) &&
                     ((mask_r & full) == '0);

  always_comb begin
    ctl.wr_mask   = (state == S_EXEC && func_r == FUNC_APPEND && append_ok) ? mask_r : '0;
    ctl.wr_minute = MIN_W'(hour_r) * MIN_W'(MIN_PER_HOUR) + MIN_W'(minute_r);
    ctl.wr_tag    = tag_r;
    ctl.q_day     = day_r;
    ctl.q_now     = now_c;
  end

  assign gt_v[0]  = '0;
  assign min_v[0] = '0;
  assign tag_v[0] = '0;
  assign chain_v[SLOTS_PER_DAY] = '0;

  for (genvar i = 0; i < SLOTS_PER_DAY; i++) begin : g_cell
    always_comb begin
      for (int d = 0; d < DAYS; d++) begin
        valid_v[i][d] = (fill[d] > FILL_W'(i));
      end
    end
    was_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .valid     (valid_v[i]),
      .left_gt   (gt_v[i]),
      .left_min  (min_v[i]),
      .left_tag  (tag_v[i]),
      .gt        (gt_v[i+1]),
      .entry_min (min_v[i+1]),
      .entry_tag (tag_v[i+1]),
      .chain_in  (chain_v[i+1]),
      .chain_out (chain_v[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      fill      <= '0;
      interval  <= RELAY_INTERVAL_RST;
      offset    <= RELAY_OFFSET_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_INTERVAL: interval <= cfg_data;
          CFG_OFFSET:   offset   <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            func_r   <= func;
            hour_r   <= hour_value;
            minute_r <= minute_value;
            mask_r   <= day_mask;
            tag_r    <= alarm_tag;
            wday_r   <= now_weekday;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_wait  <= '0;
          res_relay <= 1'b0;
          res_tag   <= '0;
          unique case (func_r)
            FUNC_CLEAR: begin
              fill   <= '0;
              res_ok <= 1'b1;
              state  <= S_DONE;
            end
            FUNC_APPEND: begin
              res_ok <= append_ok;
              if (append_ok) begin
                for (int d = 0; d < DAYS; d++) begin
                  if (mask_r[d]) fill[d] <= fill[d] + 1'b1;
                end
              end
              state <= S_DONE;
            end
            FUNC_QUERY: begin
              res_ok <= 1'b0;
              day_r  <= (wday_r == DAY_W'(DAYS)) ? '0 : wday_r;
              cnt_r  <= '0;
              state  <= S_SCAN;
            end
            default: begin
              res_ok <= 1'b0;
              state  <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          if (cnt_r == FILL_W'(SLOTS_PER_DAY)) begin
            if (chain_v[0].found) begin
              res_tag <= chain_v[0].tag;
              diff_r  <= DIFF_W'(chain_v[0].minute) - DIFF_W'(now_c);
              state   <= S_CALC;
            end else begin
              k_r   <= DAY_W'(1);
              day_r <= day_next;
              state <= S_NEXT;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_NEXT: begin
          if (fill[day_r] != '0) begin
            res_tag <= tag_v[1][day_r];
            diff_r  <= DIFF_W'(k_r) * DIFF_W'(MIN_PER_DAY) + DIFF_W'(min_v[1][day_r])
                       - DIFF_W'(now_c);
            state   <= S_CALC;
          end else if (k_r == DAY_W'(DAYS)) begin
            res_ok  <= 1'b0;
            res_tag <= '0;
            state   <= S_DONE;
          end else begin
            k_r   <= k_r + 1'b1;
            day_r <= day_next;
          end
        end
        S_CALC: begin
          wait_r <= WAIT_W'(diff_r) * WAIT_W'(SEC_PER_MIN);
          lim_r  <= LIM_W'(interval) + LIM_W'(offset);
          state  <= S_CMP;
        end
        S_CMP: begin
          res_ok <= 1'b1;
          if (wait_r > WAIT_W'(lim_r)) begin
            res_wait  <= WAIT_W'(interval);
            res_relay <= 1'b1;
          end else begin
            res_wait  <= wait_r;
            res_relay <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            op_ok     <= res_ok;
            wait_sec  <= res_wait;
            is_relay  <= res_relay;
            next_tag  <= res_tag;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> cnt_r <= FILL_W'(SLOTS_PER_DAY))
    else $error("scan counter past chain length");
  a_query_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && func_r == FUNC_QUERY) |=> state == S_SCAN)
    else $error("query did not start scan");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result presented outside done");
`endif

endmodule

@@ hw/rtl/was_cell.sv @@
// One slot position of every weekday list, with insert shift and search stage.
module was_cell (
  input  logic              clk,
  input  logic              rst,
  input  was_pkg::cell_ctl_t ctl,
  input  logic [was_pkg::DAYS-1:0] valid,
  input  logic [was_pkg::DAYS-1:0] left_gt,
  input  was_pkg::min_row_t  left_min,
  input  was_pkg::tag_row_t  left_tag,
  output logic [was_pkg::DAYS-1:0] gt,
  output was_pkg::min_row_t  entry_min,
  output was_pkg::tag_row_t  entry_tag,
  input  was_pkg::chain_t    chain_in,
  output was_pkg::chain_t    chain_out
);
  import was_pkg::*;

  logic             hit;
  logic [MIN_W-1:0] sel_min;

  always_comb begin
    for (int d = 0; d < DAYS; d++) begin
      gt[d] = !valid[d] || (entry_min[d] > ctl.wr_minute);
    end
  end

  assign sel_min = entry_min[ctl.q_day];
  assign hit     = valid[ctl.q_day] && (sel_min > ctl.q_now);

  always_ff @(posedge clk) begin
    for (int d = 0; d < DAYS; d++) begin
      if (ctl.wr_mask[d]) begin
        if (left_gt[d]) begin
          entry_min[d] <= left_min[d];
          entry_tag[d] <= left_tag[d];
        end else if (gt[d]) begin
          entry_min[d] <= ctl.wr_minute;
          entry_tag[d] <= ctl.wr_tag;
        end
      end
    end
    if (rst) begin
      chain_out <= '0;
    end else if (hit) begin
      chain_out <= '{found: 1'b1, minute: sel_min, tag: entry_tag[ctl.q_day]};
    end else begin
      chain_out <= chain_in;
    end
  end

endmodule
